// ===== rtl/core/mam_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mam_pkg: shared types and constants of the modular arithmetic unit
// Operation codes, reducer request bundle and fixed port widths.
// ----------------------------------------------------------------------------
package mam_pkg;

    // Fixed widths of the item fields
    localparam int FUNC_W    = 3;
    localparam int OPND_W    = 31;
    localparam int EXP_W     = 63;
    localparam int RAW_BITS  = 64;
    localparam int RESULT_W  = 31;
    localparam int MODULUS_W = 31;

    // Modulus after reset
    localparam logic [MODULUS_W-1:0] MODULUS_RESET = 31'd1000000007;

    // Dividend bits the reducer retires per cycle
    localparam int RED_RADIX = 4;

    // Operation codes
    typedef enum logic [FUNC_W-1:0] {
        FN_ADD  = 3'd0,
        FN_SUB  = 3'd1,
        FN_MUL  = 3'd2,
        FN_DIV  = 3'd3,
        FN_POW  = 3'd4,
        FN_NORM = 3'd5
    } func_t;

    // Reducer dividend sizes: a masked operand, a product, a 64-bit magnitude
    typedef enum logic [1:0] {
        RED_OPND = 2'd0,
        RED_PROD = 2'd1,
        RED_RAW  = 2'd2
    } red_mode_t;

    // Request from the sequencer to the reducer
    typedef struct packed {
        logic      start;
        red_mode_t mode;
    } red_req_t;

endpackage

// ===== rtl/core/modular_arithmetic_unit_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_arithmetic_unit_core: prime field arithmetic unit
// Add, subtract, multiply, divide (Fermat inverse), power and normalize
// modulo a prime held in a configuration register.
// ----------------------------------------------------------------------------
// Usage:
//   Command beat: drive func and the operand fields with start high; the beat
//   is taken at a clock edge with start high and busy low.
//   Result beat: result is shown for one cycle with done high. The receiver
//   cannot stall, so it must take the beat in that cycle.
//   Configuration: the modulus is written through cfg_valid / cfg_ready /
//   cfg_data while no command is in progress; reset loads 1000000007.
//   Modulus 0 or 1 and unknown func codes give result 0, with done high in
//   the cycle right after the command beat.
// Reducer steps at the default 31-bit residues: S = 8 for an operand, P = 16
//   for a product. Power runs square-and-multiply over the exponent bits, up
//   to a full 63-bit exponent; divide runs a power with exponent modulus-2.
//   Every modular product goes through one serial reducer that retires four
//   dividend bits per cycle.
//   One command is in flight at a time; busy falls in the cycle that the
//   result is registered, so the next command may follow at once.
// ----------------------------------------------------------------------------
module modular_arithmetic_unit_core
    import mam_pkg::*;
#(
    parameter int RESIDUE_BITS = 31
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [FUNC_W-1:0]    func,
    input  logic [OPND_W-1:0]    operand_a,
    input  logic [OPND_W-1:0]    operand_b,
    input  logic [EXP_W-1:0]     exponent,
    input  logic [RAW_BITS-1:0]  raw_value,
    output logic                 done,
    output logic [RESULT_W-1:0]  result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [MODULUS_W-1:0] cfg_data
);

    logic [RESIDUE_BITS-1:0] modulus_reg;
    logic [RESIDUE_BITS-1:0] modulus_next;
    logic                    done_reg;
    logic [RESULT_W-1:0]     result_reg;
    logic                    fin_valid;
    logic [RESIDUE_BITS-1:0] fin_value;
    logic                    ctrl_busy;
    logic                    cmd_beat;

    assign busy      = ctrl_busy;
    // Hold off a modulus beat while a command beat is offered or running
    assign cfg_ready = !ctrl_busy && !start;
    assign cmd_beat  = start && !ctrl_busy;

    // Take a modulus beat, masked to the residue width
    assign modulus_next = (cfg_valid && cfg_ready) ? cfg_data[RESIDUE_BITS-1:0]
                                                   : modulus_reg;

    // Hold the modulus and the result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MODULUS_RESET[RESIDUE_BITS-1:0];
            done_reg    <= 1'b0;
        end
        else
        begin
            modulus_reg <= modulus_next;
            done_reg    <= fin_valid;
        end
    end

    // Register the result beat
    always_ff @(posedge clk)
    begin
        if (fin_valid)
        begin
            result_reg <= RESULT_W'(fin_value);
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    mam_ctrl #(
        .RESIDUE_BITS (RESIDUE_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd_beat),
        .func      (func),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .exponent  (exponent),
        .raw_value (raw_value),
        .modulus   (modulus_reg),
        .busy      (ctrl_busy),
        .fin_valid (fin_valid),
        .fin_value (fin_value)
    );

endmodule

// ===== rtl/core/mam_reducer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mam_reducer: shared serial remainder unit
// Restoring remainder of a dividend of up to 64 bits by the modulus,
// RED_RADIX dividend bits per cycle; pulses done with the remainder.
// ----------------------------------------------------------------------------
module mam_reducer
    import mam_pkg::*;
#(
    parameter int RESIDUE_BITS = 31
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  red_req_t                req,
    input  logic [RAW_BITS-1:0]     dividend,
    input  logic [RESIDUE_BITS-1:0] modulus,
    output logic                    done,
    output logic [RESIDUE_BITS-1:0] rem
);

    localparam int OPND_STEPS = (RESIDUE_BITS + RED_RADIX - 1) / RED_RADIX;
    localparam int PROD_STEPS = (2 * RESIDUE_BITS + RED_RADIX - 1) / RED_RADIX;
    localparam int RAW_STEPS  = RAW_BITS / RED_RADIX;
    localparam int OPND_SHIFT = RAW_BITS - RED_RADIX * OPND_STEPS;
    localparam int PROD_SHIFT = RAW_BITS - RED_RADIX * PROD_STEPS;
    localparam int RAW_SHIFT  = RAW_BITS - RED_RADIX * RAW_STEPS;
    localparam int CNT_W      = $clog2(RAW_STEPS + 1);

    logic [RAW_BITS-1:0]     shift_reg;
    logic [RAW_BITS-1:0]     shift_next;
    logic [RESIDUE_BITS-1:0] rem_reg;
    logic [RESIDUE_BITS-1:0] rem_next;
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        cnt_next;
    logic                    run_reg;
    logic                    run_next;
    logic                    done_reg;
    logic                    done_next;
    logic [RESIDUE_BITS-1:0] rem_step;

    // Retire RED_RADIX dividend bits: shift in, compare, subtract
    always_comb
    begin
        logic [RESIDUE_BITS:0]   trial;
        logic [RESIDUE_BITS-1:0] part;
        part = rem_reg;
        for (int i = 0; i < RED_RADIX; i++)
        begin
            trial = {part, shift_reg[RAW_BITS-1-i]};
            if (trial >= {1'b0, modulus})
            begin
                trial = trial - {1'b0, modulus};
            end
            part = trial[RESIDUE_BITS-1:0];
        end
        rem_step = part;
    end

    // Load a new dividend left-aligned, or advance the running one
    always_comb
    begin
        shift_next = shift_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        run_next   = run_reg;
        done_next  = 1'b0;
        if (req.start)
        begin
            rem_next = '0;
            run_next = 1'b1;
            unique case (req.mode)
                RED_OPND:
                begin
                    shift_next = dividend << OPND_SHIFT;
                    cnt_next   = CNT_W'(OPND_STEPS);
                end
                RED_PROD:
                begin
                    shift_next = dividend << PROD_SHIFT;
                    cnt_next   = CNT_W'(PROD_STEPS);
                end
                RED_RAW:
                begin
                    shift_next = dividend << RAW_SHIFT;
                    cnt_next   = CNT_W'(RAW_STEPS);
                end
                default:
                begin
                    shift_next = dividend << RAW_SHIFT;
                    cnt_next   = CNT_W'(RAW_STEPS);
                end
            endcase
        end
        else if (run_reg)
        begin
            shift_next = shift_reg << RED_RADIX;
            rem_next   = rem_step;
            cnt_next   = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Hold the dividend and partial remainder
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ===== rtl/core/mam_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mam_ctrl: operation sequencer with the shared multiplier
// Reduces the operands, runs square-and-multiply for power and divide,
// and feeds every product through the shared serial reducer.
// ----------------------------------------------------------------------------
module mam_ctrl
    import mam_pkg::*;
#(
    parameter int RESIDUE_BITS = 31
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [FUNC_W-1:0]       func,
    input  logic [OPND_W-1:0]       operand_a,
    input  logic [OPND_W-1:0]       operand_b,
    input  logic [EXP_W-1:0]        exponent,
    input  logic [RAW_BITS-1:0]     raw_value,
    input  logic [RESIDUE_BITS-1:0] modulus,
    output logic                    busy,
    output logic                    fin_valid,
    output logic [RESIDUE_BITS-1:0] fin_value
);

    localparam int PROD_W = 2 * RESIDUE_BITS;

    typedef enum logic [11:0] {
        ST_IDLE    = 12'b0000_0000_0001,
        ST_RED_A   = 12'b0000_0000_0010,
        ST_RED_B   = 12'b0000_0000_0100,
        ST_DISP    = 12'b0000_0000_1000,
        ST_PW_CHK  = 12'b0000_0001_0000,
        ST_PW_MUL  = 12'b0000_0010_0000,
        ST_PW_MWT  = 12'b0000_0100_0000,
        ST_PW_SQ   = 12'b0000_1000_0000,
        ST_PW_SWT  = 12'b0001_0000_0000,
        ST_FIN_MUL = 12'b0010_0000_0000,
        ST_FIN_WT  = 12'b0100_0000_0000,
        ST_NORM_WT = 12'b1000_0000_0000
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    logic                    launch_reg;
    logic                    launch_next;
    func_t                   func_reg;
    func_t                   func_next;
    logic [RESIDUE_BITS-1:0] b_raw_reg;
    logic [RESIDUE_BITS-1:0] b_raw_next;
    logic [RESIDUE_BITS-1:0] a_reg;
    logic [RESIDUE_BITS-1:0] a_next;
    logic [RESIDUE_BITS-1:0] b_reg;
    logic [RESIDUE_BITS-1:0] b_next;
    logic [RESIDUE_BITS-1:0] acc_reg;
    logic [RESIDUE_BITS-1:0] acc_next;
    logic [RESIDUE_BITS-1:0] base_reg;
    logic [RESIDUE_BITS-1:0] base_next;
    logic [EXP_W-1:0]        e_reg;
    logic [EXP_W-1:0]        e_next;
    logic [PROD_W-1:0]       prod_reg;
    logic [PROD_W-1:0]       prod_next;
    logic                    neg_reg;
    logic                    neg_next;

    red_req_t                red_req;
    logic [RAW_BITS-1:0]     red_dividend;
    logic                    red_done;
    logic [RESIDUE_BITS-1:0] red_rem;

    logic                    mod_ok;
    logic                    func_ok;
    logic [RAW_BITS-1:0]     raw_mag;
    logic [RESIDUE_BITS-1:0] mul_x;
    logic [RESIDUE_BITS-1:0] mul_y;
    logic [RESIDUE_BITS:0]   sum;
    logic [RESIDUE_BITS:0]   diff;
    logic [RESIDUE_BITS-1:0] add_res;
    logic [RESIDUE_BITS-1:0] sub_res;
    logic [RESIDUE_BITS-1:0] norm_res;

    assign busy    = (state_reg != ST_IDLE);
    assign mod_ok  = (modulus >= RESIDUE_BITS'(2));
    assign func_ok = (func <= FN_NORM);
    assign raw_mag = raw_value[RAW_BITS-1] ? (~raw_value + RAW_BITS'(1)) : raw_value;

    // Shared multiplier operand select
    always_comb
    begin
        mul_x = acc_reg;
        mul_y = base_reg;
        if (state_reg == ST_PW_SQ)
        begin
            mul_x = base_reg;
        end
        else if (state_reg == ST_FIN_MUL)
        begin
            mul_y = a_reg;
        end
    end

    // Add and subtract of reduced residues
    always_comb
    begin
        sum  = {1'b0, a_reg} + {1'b0, b_reg};
        diff = {1'b0, a_reg} + {1'b0, modulus} - {1'b0, b_reg};
        add_res = (sum >= {1'b0, modulus}) ? RESIDUE_BITS'(sum - {1'b0, modulus})
                                           : sum[RESIDUE_BITS-1:0];
        sub_res = (a_reg >= b_reg) ? (a_reg - b_reg) : diff[RESIDUE_BITS-1:0];
    end

    // Fold a negative magnitude back to the residue range
    assign norm_res = (neg_reg && (red_rem != '0)) ? (modulus - red_rem) : red_rem;

    // Reducer request and dividend select
    always_comb
    begin
        red_req.start = 1'b0;
        red_req.mode  = RED_PROD;
        red_dividend  = RAW_BITS'(prod_reg);
        if (state_reg == ST_IDLE)
        begin
            red_req.start = start && mod_ok && func_ok;
            if (func == FN_NORM)
            begin
                red_req.mode = RED_RAW;
                red_dividend = raw_mag;
            end
            else
            begin
                red_req.mode = RED_OPND;
                red_dividend = RAW_BITS'(operand_a[RESIDUE_BITS-1:0]);
            end
        end
        else if (state_reg == ST_RED_A)
        begin
            red_req.start = red_done;
            red_req.mode  = RED_OPND;
            red_dividend  = RAW_BITS'(b_raw_reg);
        end
        else
        begin
            red_req.start = launch_reg;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        launch_next = 1'b0;
        func_next   = func_reg;
        b_raw_next  = b_raw_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        acc_next    = acc_reg;
        base_next   = base_reg;
        e_next      = e_reg;
        prod_next   = prod_reg;
        neg_next    = neg_reg;
        fin_valid   = 1'b0;
        fin_value   = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    func_next  = func_t'(func);
                    b_raw_next = operand_b[RESIDUE_BITS-1:0];
                    e_next     = exponent;
                    neg_next   = raw_value[RAW_BITS-1];
                    if (!mod_ok || !func_ok)
                    begin
                        fin_valid = 1'b1;
                    end
                    else if (func == FN_NORM)
                    begin
                        state_next = ST_NORM_WT;
                    end
                    else
                    begin
                        state_next = ST_RED_A;
                    end
                end
            end
            ST_RED_A:
            begin
                if (red_done)
                begin
                    a_next     = red_rem;
                    state_next = ST_RED_B;
                end
            end
            ST_RED_B:
            begin
                if (red_done)
                begin
                    b_next     = red_rem;
                    state_next = ST_DISP;
                end
            end
            ST_DISP:
            begin
                case (func_reg)
                    FN_ADD:
                    begin
                        fin_valid  = 1'b1;
                        fin_value  = add_res;
                        state_next = ST_IDLE;
                    end
                    FN_SUB:
                    begin
                        fin_valid  = 1'b1;
                        fin_value  = sub_res;
                        state_next = ST_IDLE;
                    end
                    FN_MUL:
                    begin
                        acc_next   = b_reg;
                        state_next = ST_FIN_MUL;
                    end
                    FN_DIV:
                    begin
                        acc_next   = RESIDUE_BITS'(1);
                        base_next  = b_reg;
                        e_next     = EXP_W'(modulus - RESIDUE_BITS'(2));
                        state_next = ST_PW_CHK;
                    end
                    FN_POW:
                    begin
                        acc_next   = RESIDUE_BITS'(1);
                        base_next  = a_reg;
                        state_next = ST_PW_CHK;
                    end
                    default:
                    begin
                        fin_valid  = 1'b1;
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_PW_CHK:
            begin
                if (e_reg == '0)
                begin
                    if (func_reg == FN_DIV)
                    begin
                        state_next = ST_FIN_MUL;
                    end
                    else
                    begin
                        fin_valid  = 1'b1;
                        fin_value  = acc_reg;
                        state_next = ST_IDLE;
                    end
                end
                else if (e_reg[0])
                begin
                    state_next = ST_PW_MUL;
                end
                else
                begin
                    state_next = ST_PW_SQ;
                end
            end
            ST_PW_MUL:
            begin
                prod_next   = PROD_W'(mul_x) * PROD_W'(mul_y);
                launch_next = 1'b1;
                state_next  = ST_PW_MWT;
            end
            ST_PW_MWT:
            begin
                if (red_done)
                begin
                    acc_next = red_rem;
                    // Skip the last squaring: nothing reads it
                    if (e_reg[EXP_W-1:1] == '0)
                    begin
                        e_next     = '0;
                        state_next = ST_PW_CHK;
                    end
                    else
                    begin
                        state_next = ST_PW_SQ;
                    end
                end
            end
            ST_PW_SQ:
            begin
                prod_next   = PROD_W'(mul_x) * PROD_W'(mul_y);
                launch_next = 1'b1;
                state_next  = ST_PW_SWT;
            end
            ST_PW_SWT:
            begin
                if (red_done)
                begin
                    base_next  = red_rem;
                    e_next     = e_reg >> 1;
                    state_next = ST_PW_CHK;
                end
            end
            ST_FIN_MUL:
            begin
                prod_next   = PROD_W'(mul_x) * PROD_W'(mul_y);
                launch_next = 1'b1;
                state_next  = ST_FIN_WT;
            end
            ST_FIN_WT:
            begin
                if (red_done)
                begin
                    fin_valid  = 1'b1;
                    fin_value  = red_rem;
                    state_next = ST_IDLE;
                end
            end
            ST_NORM_WT:
            begin
                if (red_done)
                begin
                    fin_valid  = 1'b1;
                    fin_value  = norm_res;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            launch_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= launch_next;
        end
    end

    // Hold operands and working values
    always_ff @(posedge clk)
    begin
        func_reg  <= func_next;
        b_raw_reg <= b_raw_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        acc_reg   <= acc_next;
        base_reg  <= base_next;
        e_reg     <= e_next;
        prod_reg  <= prod_next;
        neg_reg   <= neg_next;
    end

    mam_reducer #(
        .RESIDUE_BITS (RESIDUE_BITS)
    ) u_reducer (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (red_req),
        .dividend (red_dividend),
        .modulus  (modulus),
        .done     (red_done),
        .rem      (red_rem)
    );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for modular_arithmetic_unit_core
// Sends command beats through the start/busy handshake and predicts every
// residue in a prime field predictor. A monitor compares each result beat
// with the oldest prediction. Directed beats cover field extremes and the
// degenerate moduli. Random phases follow, each under its own modulus and one
// of three sender idle rates.
// ----------------------------------------------------------------------------
module testbench;
    import mam_pkg::*;

    // Function codes the block does not define
    localparam logic [FUNC_W-1:0] FN_RSVD_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FN_RSVD_7 = 3'd7;

    localparam bit [OPND_W-1:0]   OPND_ONES   = '1;
    localparam bit [EXP_W-1:0]    EXP_ONES    = '1;
    localparam bit [RAW_BITS-1:0] RAW_MIN     = 64'h8000_0000_0000_0000;
    localparam bit [RAW_BITS-1:0] RAW_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam bit [RAW_BITS-1:0] RAW_NEG_ONE = '1;
    localparam bit [MODULUS_W-1:0] MODULUS_MAX = '1;

    localparam int     RESET_CYCLES    = 11;
    localparam int     DRAIN_LIMIT     = 4000;
    localparam int     TAIL_CYCLES     = 64;
    localparam int     PHASE_BEATS     = 255;
    localparam longint TIMEOUT_NS      = 100_000_000;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [FUNC_W-1:0]    func;
    logic [OPND_W-1:0]    operand_a;
    logic [OPND_W-1:0]    operand_b;
    logic [EXP_W-1:0]     exponent;
    logic [RAW_BITS-1:0]  raw_value;
    logic                 done;
    logic [RESULT_W-1:0]  result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [MODULUS_W-1:0] cfg_data;

    // Predictor state: the modulus as last written
    bit [MODULUS_W-1:0] field_modulus = MODULUS_RESET;
    bit [RESULT_W-1:0]  pending_residues[$];
    bit [RESULT_W-1:0]  oldest_residue;
    int                 error_count = 0;

    modular_arithmetic_unit_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .func      (func),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .exponent  (exponent),
        .raw_value (raw_value),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Free-running clock, 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Square-and-multiply from the low exponent bit upward
    function automatic bit [63:0] mod_pow(bit [63:0] base, bit [63:0] expo, bit [63:0] m);
        bit [63:0] acc;
        acc = 64'd1 % m;
        while (expo != 0)
        begin
            if (expo[0])
                acc = (acc * base) % m;
            base = (base * base) % m;
            expo = expo >> 1;
        end
        return acc;
    endfunction

    // Residue that one command beat yields under the current modulus
    function automatic bit [RESULT_W-1:0] calc_residue(logic [FUNC_W-1:0] op,
                                                      bit [OPND_W-1:0] a_in,
                                                      bit [OPND_W-1:0] b_in,
                                                      bit [EXP_W-1:0] e_in,
                                                      bit [RAW_BITS-1:0] raw_in);
        bit [63:0] m;
        bit [63:0] a;
        bit [63:0] b;
        bit [63:0] r;
        bit [63:0] rem;
        m = 64'(field_modulus);
        r = 0;
        if (m >= 2)
        begin
            a = a_in % m;
            b = b_in % m;
            case (op)
                FN_ADD:  r = (a + b) % m;
                FN_SUB:  r = (a >= b) ? (a - b) : (a + m - b);
                FN_MUL:  r = (a * b) % m;
                FN_DIV:  r = (a * mod_pow(b, m - 2, m)) % m;
                FN_POW:  r = mod_pow(a, 64'(e_in), m);
                FN_NORM:
                begin
                    if (raw_in[63])
                    begin
                        rem = (~raw_in + 64'd1) % m;
                        r = (rem != 0) ? (m - rem) : 0;
                    end
                    else
                        r = raw_in % m;
                end
                default: r = 0;
            endcase
        end
        return r[RESULT_W-1:0];
    endfunction

    function automatic bit [OPND_W-1:0] rand_opnd();
        return OPND_W'($urandom);
    endfunction

    function automatic bit [EXP_W-1:0] rand_exp();
        return EXP_W'({$urandom, $urandom});
    endfunction

    function automatic bit [RAW_BITS-1:0] rand_raw();
        return {$urandom, $urandom};
    endfunction

    // Send one command beat; start stays high after the beat is taken
    task automatic issue_cmd(logic [FUNC_W-1:0] op, bit [OPND_W-1:0] a,
                             bit [OPND_W-1:0] b, bit [EXP_W-1:0] e,
                             bit [RAW_BITS-1:0] raw);
        start     <= 1'b1;
        func      <= op;
        operand_a <= a;
        operand_b <= b;
        exponent  <= e;
        raw_value <= raw;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_residues.push_back(calc_residue(op, a, b, e, raw));
    endtask

    // Hold start low for a random stretch, at the given percentage
    task automatic sender_gap(int idle_pct);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 40))
                @(posedge clk);
        end
    endtask

    // Drop start and wait until every predicted beat has come back
    task automatic drain_results();
        int waited = 0;
        start <= 1'b0;
        @(negedge clk);
        while (pending_residues.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        if (pending_residues.size() != 0)
        begin
            $error("%0d result beats never arrived", pending_residues.size());
            error_count += pending_residues.size();
            pending_residues.delete();
        end
        @(posedge clk);
    endtask

    // Write the modulus once the block is idle
    task automatic set_modulus(bit [MODULUS_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        field_modulus = value;
    endtask

    // Field extremes and every operation under the reset modulus
    task automatic test_field_extremes();
        bit [OPND_W-1:0] top;
        top = OPND_W'(MODULUS_RESET - 1);
        issue_cmd(FN_ADD, 0, 0, rand_exp(), rand_raw());
        issue_cmd(FN_ADD, top, top, rand_exp(), rand_raw());
        // operands at or above the modulus
        issue_cmd(FN_ADD, OPND_ONES, OPND_ONES, rand_exp(), rand_raw());
        issue_cmd(FN_SUB, 0, 1, rand_exp(), rand_raw());
        issue_cmd(FN_MUL, top, top, rand_exp(), rand_raw());
        issue_cmd(FN_MUL, OPND_ONES, OPND_ONES, rand_exp(), rand_raw());
        // divide by zero, then a plain inverse
        issue_cmd(FN_DIV, 31'd12345, 0, rand_exp(), rand_raw());
        issue_cmd(FN_DIV, 1, 2, rand_exp(), rand_raw());
        issue_cmd(FN_POW, 0, rand_opnd(), 0, rand_raw());
        issue_cmd(FN_POW, 0, rand_opnd(), 63'd7, rand_raw());
        issue_cmd(FN_POW, 3, rand_opnd(), EXP_ONES, rand_raw());
        issue_cmd(FN_NORM, rand_opnd(), rand_opnd(), rand_exp(), RAW_MIN);
        issue_cmd(FN_NORM, rand_opnd(), rand_opnd(), rand_exp(), RAW_MAX);
        issue_cmd(FN_NORM, rand_opnd(), rand_opnd(), rand_exp(), RAW_NEG_ONE);
        issue_cmd(FN_NORM, rand_opnd(), rand_opnd(), rand_exp(), 0);
        issue_cmd(FN_RSVD_6, rand_opnd(), rand_opnd(), rand_exp(), rand_raw());
        issue_cmd(FN_RSVD_7, rand_opnd(), rand_opnd(), rand_exp(), rand_raw());
    endtask

    // Moduli zero and one, the primes two and three, and the largest value
    task automatic test_degenerate_moduli();
        set_modulus(0);
        issue_cmd(FN_ADD, 5, 7, rand_exp(), rand_raw());
        issue_cmd(FN_DIV, 5, 7, rand_exp(), rand_raw());
        set_modulus(1);
        issue_cmd(FN_POW, 5, 7, 0, rand_raw());
        set_modulus(2);
        issue_cmd(FN_DIV, 5, 0, rand_exp(), rand_raw());
        issue_cmd(FN_POW, 1, 0, 63'd9, rand_raw());
        set_modulus(3);
        issue_cmd(FN_SUB, 0, 2, rand_exp(), rand_raw());
        issue_cmd(FN_DIV, 2, 2, rand_exp(), rand_raw());
        set_modulus(MODULUS_MAX);
        issue_cmd(FN_DIV, OPND_ONES, 3, rand_exp(), rand_raw());
        issue_cmd(FN_NORM, rand_opnd(), rand_opnd(), rand_exp(), RAW_MIN);
    endtask

    // Random operations; slow powers mostly use short exponents
    task automatic test_random_mix();
        bit [MODULUS_W-1:0] moduli[7];
        int                 idle_pct[3];
        logic [FUNC_W-1:0]  op;
        bit [OPND_W-1:0]    ab[2];
        bit [EXP_W-1:0]     e;
        bit [RAW_BITS-1:0]  raw;
        int                 pick;
        moduli   = '{MODULUS_RESET, MODULUS_MAX, 31'd3, 31'd65521, 31'd251, 0, 0};
        moduli[5] = MODULUS_W'($urandom);
        moduli[6] = MODULUS_W'($urandom_range(2, 4096));
        idle_pct = '{0, 52, 24};
        for (int phase = 0; phase < 7; phase++)
        begin
            set_modulus(moduli[phase]);
            repeat (PHASE_BEATS)
            begin
                pick = $urandom_range(99);
                if (pick < 18)      op = FN_ADD;
                else if (pick < 36) op = FN_SUB;
                else if (pick < 54) op = FN_MUL;
                else if (pick < 72) op = FN_NORM;
                else if (pick < 82) op = FN_DIV;
                else if (pick < 94) op = FN_POW;
                else if (pick < 97) op = FN_RSVD_6;
                else                op = FN_RSVD_7;
                for (int k = 0; k < 2; k++)
                begin
                    case ($urandom_range(9))
                        0:       ab[k] = 0;
                        1:       ab[k] = OPND_W'(field_modulus - 1);
                        2:       ab[k] = OPND_ONES;
                        3:       ab[k] = rand_opnd();
                        default: ab[k] = (field_modulus != 0)
                                         ? OPND_W'($urandom % field_modulus)
                                         : rand_opnd();
                    endcase
                end
                case ($urandom_range(15))
                    0:       e = 0;
                    1:       e = EXP_ONES;
                    2:       e = rand_exp();
                    default: e = EXP_W'(rand_exp() & ((64'd1 << $urandom_range(20)) - 1));
                endcase
                case ($urandom_range(7))
                    0:       raw = RAW_MIN;
                    1:       raw = RAW_MAX;
                    2:       raw = RAW_NEG_ONE;
                    3:       raw = 0;
                    default:
                    begin
                        raw = rand_raw() >> $urandom_range(63);
                        if ($urandom_range(1))
                            raw = -raw;
                    end
                endcase
                sender_gap(idle_pct[phase % 3]);
                issue_cmd(op, ab[0], ab[1], e, raw);
            end
        end
    endtask

    // Compare each result beat with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_residues.size() == 0)
            begin
                $error("result beat with nothing expected: result=%0d", result);
                error_count++;
            end
            else
            begin
                oldest_residue = pending_residues.pop_front();
                if (result !== oldest_residue)
                begin
                    $error("result mismatch: result expected %0d actual %0d",
                           oldest_residue, result);
                    error_count++;
                end
            end
        end
    end

    // Main sequence
    initial
    begin
        rst_n     <= 1'b0;
        start     <= 1'b0;
        func      <= FN_ADD;
        operand_a <= '0;
        operand_b <= '0;
        exponent  <= '0;
        raw_value <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_degenerate_moduli();
        test_random_mix();

        drain_results();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
